// ===== src/irdig_pkg.sv =====
// Package: shared types and constants for the integer to radix digits block.
`timescale 1ns / 1ps

package irdig_pkg;

    localparam int unsigned STEP_BITS = 4;

    localparam logic [7:0] PLUS_CHAR  = 8'd43;
    localparam logic [7:0] MINUS_CHAR = 8'd45;
    localparam logic [7:0] ZERO_CHAR  = 8'd0;

    localparam logic [4:0]  RADIX_LENGTH_RESET  = 5'd10;
    localparam logic [63:0] ALPHABET_LOW_RESET  = 64'h3736_3534_3332_3130;
    localparam logic [63:0] ALPHABET_HIGH_RESET = 64'h0;

    typedef enum logic [1:0] {
        REG_RADIX_LENGTH  = 2'd0,
        REG_ALPHABET_LOW  = 2'd1,
        REG_ALPHABET_HIGH = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ERR,
        ST_DIV,
        ST_READ,
        ST_LOAD
    } state_t;

endpackage

// ===== src/integer_to_radix_digits.sv =====
// Top level: converts an unsigned value into alphabet characters, most significant digit first.
// Steps: check the L alphabet characters one by one (L = radix length), then divide the value by
// the radix a nibble at a time for each digit, then show the stored digits one by one.
// Requests: one at a time; a new one is taken only once the last digit is in the output register.
// An invalid alphabet gives a single error result.
// Reset clears control state and restores the default radix and alphabet; no clearing pass.
`timescale 1ns / 1ps

module integer_to_radix_digits #(
    parameter int unsigned MAX_RADIX  = 16,
    parameter int unsigned VALUE_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] value,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  digit_char,
    output logic        last_digit,
    output logic        invalid_alphabet
);

    localparam int unsigned DIG_W = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
    localparam int unsigned NCH   = (VALUE_BITS + irdig_pkg::STEP_BITS - 1)
                                    / irdig_pkg::STEP_BITS;
    localparam int unsigned QW    = NCH * irdig_pkg::STEP_BITS;
    localparam int unsigned SW    = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int unsigned AW    = $clog2(VALUE_BITS);

    function automatic logic [7:0] alpha_char(input logic [127:0] alpha,
                                              input logic [3:0]   idx);
        alpha_char = alpha[{idx, 3'b000} +: 8];
    endfunction

    irdig_pkg::state_t state_reg, state_next;

    logic [4:0]       radix_length_reg;
    logic [63:0]      alphabet_low_reg;
    logic [63:0]      alphabet_high_reg;

    logic [3:0]       chk_idx_reg, chk_idx_next;
    logic [SW-1:0]    step_reg, step_next;
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic             out_valid_reg, out_valid_next;

    logic [QW-1:0]    quot_reg, quot_next;
    logic [DIG_W-1:0] rem_reg, rem_next;
    logic             qnz_reg, qnz_next;
    logic [7:0]       digit_char_reg, digit_char_next;
    logic             last_digit_reg, last_digit_next;
    logic             invalid_reg, invalid_next;

    logic [DIG_W-1:0] store_mem [VALUE_BITS];
    logic [DIG_W-1:0] rd_data_reg;
    logic             mem_we;

    logic [127:0]     alpha;
    logic [7:0]       chk_char;
    logic             len_bad;
    logic             char_bad;
    logic             chk_done;
    logic [DIG_W:0]   radix;
    logic [QW-1:0]    quot_step;
    logic [DIG_W-1:0] rem_step;
    logic             qbits_any;
    logic             last_step;
    logic             out_free;
    logic             in_fire;

    assign alpha    = {alphabet_high_reg, alphabet_low_reg};
    assign chk_char = alpha_char(alpha, chk_idx_reg);
    assign len_bad  = (radix_length_reg < 5'd2) || (radix_length_reg > 5'(MAX_RADIX));
    assign chk_done = ({1'b0, chk_idx_reg} == (radix_length_reg - 5'd1));
    assign radix    = radix_length_reg[DIG_W:0];
    assign last_step = (step_reg == SW'(NCH - 1));
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == irdig_pkg::ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        char_bad = (chk_char == irdig_pkg::ZERO_CHAR) || (chk_char == irdig_pkg::PLUS_CHAR)
                   || (chk_char == irdig_pkg::MINUS_CHAR);
        for (int j = 0; j < 16; j++)
        begin
            if ((4'(j) > chk_idx_reg) && (5'(j) < radix_length_reg)
                && (alpha_char(alpha, 4'(j)) == chk_char))
            begin
                char_bad = 1'b1;
            end
        end
    end

    // Divide one nibble of the running quotient by the radix.
    always_comb
    begin
        logic [DIG_W:0] t;
        logic           qb;
        quot_step = quot_reg;
        rem_step  = rem_reg;
        qbits_any = 1'b0;
        for (int b = 0; b < int'(irdig_pkg::STEP_BITS); b++)
        begin
            t         = {rem_step, quot_step[QW-1]};
            qb        = (t >= radix);
            rem_step  = qb ? DIG_W'(t - radix) : t[DIG_W-1:0];
            quot_step = {quot_step[QW-2:0], qb};
            qbits_any = qbits_any | qb;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        chk_idx_next    = chk_idx_reg;
        step_next       = step_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        out_valid_next  = (out_valid_reg && out_ready) ? 1'b0 : out_valid_reg;
        quot_next       = quot_reg;
        rem_next        = rem_reg;
        qnz_next        = qnz_reg;
        digit_char_next = digit_char_reg;
        last_digit_next = last_digit_reg;
        invalid_next    = invalid_reg;
        mem_we          = 1'b0;

        unique case (state_reg)
            irdig_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    quot_next    = QW'(value[VALUE_BITS-1:0]);
                    rem_next     = '0;
                    qnz_next     = 1'b0;
                    step_next    = '0;
                    wr_ptr_next  = '0;
                    chk_idx_next = '0;
                    state_next   = irdig_pkg::ST_CHECK;
                end
            end
            irdig_pkg::ST_CHECK:
            begin
                if (len_bad || char_bad)
                begin
                    state_next = irdig_pkg::ST_ERR;
                end
                else if (chk_done)
                begin
                    state_next = irdig_pkg::ST_DIV;
                end
                else
                begin
                    chk_idx_next = chk_idx_reg + 4'd1;
                end
            end
            irdig_pkg::ST_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    digit_char_next = irdig_pkg::ZERO_CHAR;
                    last_digit_next = 1'b1;
                    invalid_next    = 1'b1;
                    state_next      = irdig_pkg::ST_IDLE;
                end
            end
            irdig_pkg::ST_DIV:
            begin
                quot_next = quot_step;
                rem_next  = rem_step;
                qnz_next  = qnz_reg | qbits_any;
                step_next = step_reg + SW'(1);
                if (last_step)
                begin
                    mem_we      = 1'b1;
                    wr_ptr_next = wr_ptr_reg + AW'(1);
                    rem_next    = '0;
                    qnz_next    = 1'b0;
                    step_next   = '0;
                    if (!(qnz_reg | qbits_any))
                    begin
                        rd_ptr_next = wr_ptr_reg;
                        state_next  = irdig_pkg::ST_READ;
                    end
                end
            end
            irdig_pkg::ST_READ:
            begin
                state_next = irdig_pkg::ST_LOAD;
            end
            irdig_pkg::ST_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    digit_char_next = alpha_char(alpha, 4'(rd_data_reg));
                    last_digit_next = (rd_ptr_reg == '0);
                    invalid_next    = 1'b0;
                    if (rd_ptr_reg == '0)
                    begin
                        state_next = irdig_pkg::ST_IDLE;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg - AW'(1);
                        state_next  = irdig_pkg::ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = irdig_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= irdig_pkg::ST_IDLE;
            chk_idx_reg   <= '0;
            step_reg      <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_idx_reg   <= chk_idx_next;
            step_reg      <= step_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_length_reg  <= irdig_pkg::RADIX_LENGTH_RESET;
            alphabet_low_reg  <= irdig_pkg::ALPHABET_LOW_RESET;
            alphabet_high_reg <= irdig_pkg::ALPHABET_HIGH_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                irdig_pkg::REG_RADIX_LENGTH:  radix_length_reg  <= cfg_data[4:0];
                irdig_pkg::REG_ALPHABET_LOW:  alphabet_low_reg  <= cfg_data;
                irdig_pkg::REG_ALPHABET_HIGH: alphabet_high_reg <= cfg_data;
                default:
                begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg       <= quot_next;
        rem_reg        <= rem_next;
        qnz_reg        <= qnz_next;
        digit_char_reg <= digit_char_next;
        last_digit_reg <= last_digit_next;
        invalid_reg    <= invalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[wr_ptr_reg] <= rem_step;
        end
        rd_data_reg <= store_mem[rd_ptr_reg];
    end

    assign out_valid        = out_valid_reg;
    assign digit_char       = digit_char_reg;
    assign last_digit       = last_digit_reg;
    assign invalid_alphabet = invalid_reg;

endmodule

// ===== src/irdig_checker.sv =====
// Checker: port-level assertions for the integer to radix digits block, with its bind.
`timescale 1ns / 1ps

module irdig_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] digit_char,
    input logic       last_digit,
    input logic       invalid_alphabet
);

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && invalid_alphabet |-> last_digit && (digit_char == 8'd0))
        else $error("error result without last flag or with nonzero character");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("new request taken while one is in work");

    a_idle_tail: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> last_digit)
        else $error("idle while a non-final digit waits");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digit_char) && $stable(last_digit)
        && $stable(invalid_alphabet))
        else $error("stalled result changed");

endmodule

bind integer_to_radix_digits irdig_checker u_irdig_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .digit_char       (digit_char),
    .last_digit       (last_digit),
    .invalid_alphabet (invalid_alphabet)
);
